FILE: rtl/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every edge, reset included.
`define LGSM_ASSERT(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

// Property checked outside reset only.
`define LGSM_ASSERT_DIS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

FILE: rtl/lgsm_pkg.sv
package lgsm_pkg;

   localparam int PatternMaxDefault = 32;
   localparam int PatternRegBytes   = 32;
   localparam int PatternWords      = 4;
   localparam int ByteIdxW          = $clog2(PatternRegBytes);
   localparam int LenW              = 6;
   localparam int CntW              = 32;
   localparam int CsrIndexW         = 3;
   localparam int CsrDataW          = 64;
   localparam int QueueDepth        = 4;

   localparam logic [CntW-1:0] CntMax      = '1;
   localparam logic [7:0]      NewlineByte = 8'h0A;
   localparam logic [7:0]      UpperFirst  = 8'h41;
   localparam logic [7:0]      UpperLast   = 8'h5A;
   localparam logic [7:0]      FoldOffset  = 8'h20;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_PATTERN_LENGTH,
      CSR_PATTERN_0_7,
      CSR_PATTERN_8_15,
      CSR_PATTERN_16_23,
      CSR_PATTERN_24_31,
      CSR_MATCH_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic       func;
      logic [7:0] ch;
   } req_item_type;

   typedef struct packed {
      logic [CntW-1:0] file_index;
      logic [CntW-1:0] line_num;
      logic [CntW-1:0] column;
      logic            truncated;
   } rsp_item_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_NEWLINE,
      KIND_EOF
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    ch;
   } work_item_type;

   typedef struct packed {
      logic            fold_en;
      logic [LenW-1:0] eff_len;
      logic [CntW-1:0] match_limit;
   } match_cfg_type;

   function automatic logic is_upper(input logic [7:0] b);
      return (b >= UpperFirst) && (b <= UpperLast);
   endfunction

   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      return is_upper(b) ? (b + FoldOffset) : b;
   endfunction

   function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
      return (v == CntMax) ? v : (v + CntW'(1));
   endfunction

endpackage

FILE: rtl/lgsm_fifo.sv
module lgsm_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [Width-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [Width-1:0] rd_data,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CntW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/lgsm_front.sv
module lgsm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  lgsm_pkg::req_item_type   req_data,
   output logic                     req_full,
   output logic                     item_valid,
   output lgsm_pkg::work_item_type  item,
   input  logic                     item_pop
);

   import lgsm_pkg::*;

   work_item_type             classified;
   logic [$bits(work_item_type)-1:0] head_bits;
   logic                      queue_empty;

   // Sort each transaction into data byte, line end or file end.
   always_comb begin
      classified.ch = req_data.ch;
      if (req_data.func) begin
         classified.kind = KIND_EOF;
      end else if (req_data.ch == NewlineByte) begin
         classified.kind = KIND_NEWLINE;
      end else begin
         classified.kind = KIND_DATA;
      end
   end

   lgsm_fifo #(
      .Width ($bits(work_item_type)),
      .Depth (QueueDepth)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push),
      .wr_data (classified),
      .full    (req_full),
      .rd_en   (item_pop),
      .rd_data (head_bits),
      .empty   (queue_empty)
   );

   assign item_valid = !queue_empty;
   assign item       = work_item_type'(head_bits);

endmodule

FILE: rtl/lgsm_csr.sv
module lgsm_csr #(
   parameter int PATTERN_MAX = lgsm_pkg::PatternMaxDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lgsm_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [lgsm_pkg::CsrDataW-1:0]        csr_wdata,
   output lgsm_pkg::match_cfg_type              cfg,
   output logic [PATTERN_MAX-1:0][7:0]          cfg_pattern,
   output logic [PATTERN_MAX-1:0]               cfg_mask
);

   import lgsm_pkg::*;

   logic [LenW-1:0]                          length_ff, length_in;
   logic [PatternWords-1:0][CsrDataW-1:0]    words_ff, words_in;
   logic [CntW-1:0]                          limit_ff, limit_in;
   logic [PatternRegBytes-1:0][7:0]          pbytes;

   // Pattern laid out against the byte window: slot k meets byte k back from the newest.
   logic [PATTERN_MAX-1:0][7:0]              pattern_ff, pattern_in;
   logic [PATTERN_MAX-1:0]                   mask_ff, mask_in;
   logic                                     fold_ff, fold_in;
   logic [LenW-1:0]                          eff_ff, eff_in;
   logic                                     csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      length_in = length_ff;
      words_in  = words_ff;
      limit_in  = limit_ff;
      if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH: length_in   = csr_wdata[LenW-1:0];
            CSR_PATTERN_0_7:    words_in[0] = csr_wdata;
            CSR_PATTERN_8_15:   words_in[1] = csr_wdata;
            CSR_PATTERN_16_23:  words_in[2] = csr_wdata;
            CSR_PATTERN_24_31:  words_in[3] = csr_wdata;
            CSR_MATCH_LIMIT:    limit_in    = csr_wdata[CntW-1:0];
            default: ;
         endcase
      end
   end

   assign pbytes = words_in;

   // Derive the aligned pattern from the values being written, so it is ready at once.
   always_comb begin
      logic [LenW-1:0] idx;
      logic            upper;
      idx    = '0;
      upper  = 1'b0;
      eff_in = ({1'b0, length_in} > (LenW + 1)'(PATTERN_MAX)) ? LenW'(PATTERN_MAX)
                                                               : length_in;
      for (int i = 0; i < PatternRegBytes; i++) begin
         if (((LenW + 1)'(i) < {1'b0, eff_in}) && is_upper(pbytes[i])) begin
            upper = 1'b1;
         end
      end
      fold_in = !upper;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         mask_in[k]    = ((LenW + 1)'(k) < {1'b0, eff_in});
         idx           = eff_in - LenW'(k) - LenW'(1);
         pattern_in[k] = 8'h00;
         if (mask_in[k] && (idx < LenW'(PatternRegBytes))) begin
            pattern_in[k] = pbytes[idx[ByteIdxW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         words_ff  <= '0;
         limit_ff  <= CntMax;
         mask_ff   <= '0;
         fold_ff   <= 1'b1;
         eff_ff    <= '0;
      end else begin
         length_ff <= length_in;
         words_ff  <= words_in;
         limit_ff  <= limit_in;
         mask_ff   <= mask_in;
         fold_ff   <= fold_in;
         eff_ff    <= eff_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
   end

   assign cfg.fold_en     = fold_ff;
   assign cfg.eff_len     = eff_ff;
   assign cfg.match_limit = limit_ff;
   assign cfg_pattern     = pattern_ff;
   assign cfg_mask        = mask_ff;

endmodule

FILE: rtl/lgsm_back.sv
module lgsm_back #(
   parameter int PATTERN_MAX = lgsm_pkg::PatternMaxDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  lgsm_pkg::work_item_type      item,
   output logic                         item_pop,
   input  lgsm_pkg::match_cfg_type      cfg,
   input  logic [PATTERN_MAX-1:0][7:0]  cfg_pattern,
   input  logic [PATTERN_MAX-1:0]       cfg_mask,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output lgsm_pkg::rsp_item_type       rsp_data
);

   import lgsm_pkg::*;

   logic [PATTERN_MAX-1:0][7:0] recent_ff, recent_in;
   logic [PATTERN_MAX-1:0][7:0] window;
   logic [CntW-1:0]             bytes_ff, bytes_in;
   logic [CntW-1:0]             line_ff, line_in;
   logic                        hit_ff, hit_in;
   logic [CntW-1:0]             col_ff, col_in;
   logic [CntW-1:0]             matches_ff, matches_in;
   logic [CntW-1:0]             file_ff, file_in;
   logic [CntW-1:0]             bytes_next;
   logic [CntW-1:0]             matches_next;
   logic                        window_hit;
   logic                        res_full;
   logic                        emit;
   rsp_item_type                result;
   logic [$bits(rsp_item_type)-1:0] head_bits;

   assign item_pop = item_valid && !res_full;

   // Window with the incoming byte as the newest entry.
   always_comb begin
      logic [7:0] probe;
      probe      = '0;
      window[0]  = item.ch;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         window[k] = recent_ff[k-1];
      end
      window_hit = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         probe = cfg.fold_en ? fold_byte(window[k]) : window[k];
         if (cfg_mask[k] && (probe != cfg_pattern[k])) begin
            window_hit = 1'b0;
         end
      end
   end

   assign bytes_next   = sat_inc(bytes_ff);
   assign matches_next = sat_inc(matches_ff);

   always_comb begin
      result.file_index = file_ff;
      result.line_num   = line_ff;
      result.column     = col_ff;
      result.truncated  = (matches_next >= cfg.match_limit);
   end

   always_comb begin
      recent_in  = recent_ff;
      bytes_in   = bytes_ff;
      line_in    = line_ff;
      hit_in     = hit_ff;
      col_in     = col_ff;
      matches_in = matches_ff;
      file_in    = file_ff;
      emit       = 1'b0;
      if (item_pop) begin
         case (item.kind) inside
            KIND_DATA: begin
               recent_in = window;
               bytes_in  = bytes_next;
               if (!hit_ff && (cfg.eff_len != '0) &&
                   (bytes_next >= CntW'(cfg.eff_len)) && window_hit) begin
                  hit_in = 1'b1;
                  col_in = bytes_next - CntW'(cfg.eff_len) + CntW'(1);
               end
            end
            KIND_NEWLINE, KIND_EOF: begin
               // Close the line; report it while under the limit.
               if (hit_ff && (matches_ff < cfg.match_limit)) begin
                  emit       = 1'b1;
                  matches_in = matches_next;
               end
               hit_in   = 1'b0;
               col_in   = '0;
               bytes_in = '0;
               if (item.kind == KIND_EOF) begin
                  file_in = sat_inc(file_ff);
                  line_in = CntW'(1);
               end else begin
                  line_in = sat_inc(line_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff   <= '0;
         line_ff    <= CntW'(1);
         hit_ff     <= 1'b0;
         col_ff     <= '0;
         matches_ff <= '0;
         file_ff    <= '0;
      end else begin
         bytes_ff   <= bytes_in;
         line_ff    <= line_in;
         hit_ff     <= hit_in;
         col_ff     <= col_in;
         matches_ff <= matches_in;
         file_ff    <= file_in;
      end
   end

   // Only bytes of the current line are ever compared, so no clear is needed.
   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
   end

   lgsm_fifo #(
      .Width ($bits(rsp_item_type)),
      .Depth (QueueDepth)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (emit),
      .wr_data (result),
      .full    (res_full),
      .rd_en   (rsp_pop),
      .rd_data (head_bits),
      .empty   (rsp_empty)
   );

   assign rsp_data = rsp_item_type'(head_bits);

endmodule

FILE: rtl/line_grep_smartcase_matcher_core.sv
// Fixed-string line search with smartcase folding. Push one byte or an end-of-file
// transaction per cycle; each line that holds the pattern yields one result (file, line,
// first column) when its newline or end of file arrives, while the match limit is not
// reached. The block sustains one input transaction per clock: the back stage retires
// one queued item each cycle while the result queue has room, with a combinational
// compare of the whole byte window against the pattern. A result enters the result
// queue as its closing transaction is popped from the four-entry input queue; the line
// is closed as the item leaves it. Input stalls only when the four-entry result queue
// backs up and fills the input queue behind it. The configuration port is always
// ready; write it only with the block drained.
module line_grep_smartcase_matcher_core #(
   parameter int PATTERN_MAX = lgsm_pkg::PatternMaxDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  lgsm_pkg::req_item_type           req_data,
   output logic                             req_full,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output lgsm_pkg::rsp_item_type           rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lgsm_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [lgsm_pkg::CsrDataW-1:0]    csr_wdata
);

   import lgsm_pkg::*;

   logic                        item_valid;
   logic                        item_pop;
   work_item_type               item;
   match_cfg_type               cfg;
   logic [PATTERN_MAX-1:0][7:0] cfg_pattern;
   logic [PATTERN_MAX-1:0]      cfg_mask;

   lgsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   lgsm_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .cfg_pattern (cfg_pattern),
      .cfg_mask    (cfg_mask)
   );

   lgsm_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .cfg         (cfg),
      .cfg_pattern (cfg_pattern),
      .cfg_mask    (cfg_mask),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: rtl/lgsm_checker.sv
`include "assert_macros.svh"

module lgsm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input lgsm_pkg::rsp_item_type   rsp_data
);

   import lgsm_pkg::*;

   // Both queues come out of reset drained.
   `LGSM_ASSERT(a_reset_drains, clock, reset |=> !req_full && rsp_empty)

   // A waiting result holds until it is taken.
   `LGSM_ASSERT_DIS(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))

   // Line and column are one-based and never wrap to zero.
   `LGSM_ASSERT_DIS(a_rsp_one_based, clock, reset, !rsp_empty |-> rsp_data.line_num != '0 && rsp_data.column != '0)

endmodule

bind line_grep_smartcase_matcher_core lgsm_checker u_checker (.*);
